/* design/sfca_pkg.sv */
// sfca_pkg: shared types and constants for the sector flash card access block
// request and result beat structs, request codes, configuration register indexes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sfca_pkg;

	// request codes
	localparam logic [1:0] REQ_SET_SECTOR = 2'd0;
	localparam logic [1:0] REQ_READ       = 2'd1;
	localparam logic [1:0] REQ_WRITE      = 2'd2;
	localparam logic [1:0] REQ_ERASE      = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_SECTOR_DATA_BYTES   = 2'd0;
	localparam logic [1:0] CFG_ERASE_BLOCK_SECTORS = 2'd1;
	localparam logic [1:0] CFG_TOTAL_SECTORS       = 2'd2;

	// register widths
	localparam int SDB_W = 11;
	localparam int EBS_W = 7;
	localparam int TS_W  = 15;
	localparam int CFG_W = 15;

	// register reset values
	localparam logic [SDB_W-1:0] SDB_RESET = 11'd512;
	localparam logic [EBS_W-1:0] EBS_RESET = 7'd16;
	localparam logic [TS_W-1:0]  TS_RESET  = 15'd16384;

	// field widths
	localparam int SECTOR_W = 16;
	localparam int OFFSET_W = 24;
	localparam int BYTE_W   = 8;
	localparam int RUN_W    = 7;

	// status codes
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_OOR = 1'b1;

	localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hff;

	typedef struct packed {
		logic [1:0]          req_type;
		logic [SECTOR_W-1:0] new_sector;
		logic [BYTE_W-1:0]   write_data;
		logic [RUN_W-1:0]    read_length;
	} req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] read_data;
		logic              status;
		logic              last_of_run;
	} res_t;

endpackage

`default_nettype wire

/* design/sfca_ram.sv */
// sfca_ram: generic single-clock RAM with one write and one registered read port
// used for the card byte store; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module sfca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* design/sector_flash_card_access.sv */
// sector_flash_card_access: top level of the sector addressed card byte store
// depends on sfca_pkg and sfca_ram
`timescale 1ns / 1ps
`default_nettype none

// Sector addressed card store. A request is taken when start is high and busy is low.
// Set sector completes at once and leaves busy low. A write keeps busy high after it is
// taken, through S_MUL, S_ADD and S_CHK: S_MUL forms the sector base, card limit and
// erase span with three small multipliers, S_ADD adds the offset and clamps the card
// end, and S_CHK checks bounds and writes the single RAM port. Read goes through the
// same setup states and then walks the RAM read port one byte per cycle; results come
// out one per cycle, behind the RAM output register and the result beat register,
// marked by strobe. The receiver cannot stall and must take each one in its cycle; up
// to two beats of a run come out after busy has dropped. An out-of-range read gives one
// result in the cycle after the check. Erase goes through the same setup states and
// then fills one byte per cycle of the block, that is erase_block_sectors *
// (sector_data_bytes + SPARE_BYTES) bytes, through the single RAM write port. The
// store has no clearing pass after reset.
module sector_flash_card_access #(
	parameter int CARD_BYTES   = 8650752,
	parameter int SPARE_BYTES  = 16,
	parameter int MAX_READ_RUN = 64
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire sfca_pkg::req_t            req,
	output logic                           strobe,
	output sfca_pkg::res_t                 result,
	input  wire logic                      cfg_we,
	input  wire logic [1:0]                cfg_index,
	input  wire logic [sfca_pkg::CFG_W-1:0] cfg_data
);

	localparam int ADDR_W   = $clog2(CARD_BYTES);
	localparam int STRIDE_W = $clog2((1 << sfca_pkg::SDB_W) + SPARE_BYTES);
	localparam int SEC_W    = sfca_pkg::SECTOR_W + STRIDE_W;
	localparam int LIM_W    = sfca_pkg::TS_W + STRIDE_W;
	localparam int SPAN_W   = sfca_pkg::EBS_W + STRIDE_W;
	localparam int POS_W    = SEC_W + 1;
	localparam int END_W    = $clog2(CARD_BYTES + 1);

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL   = 3'd1;
	localparam logic [2:0] S_ADD   = 3'd2;
	localparam logic [2:0] S_CHK   = 3'd3;
	localparam logic [2:0] S_READ  = 3'd4;
	localparam logic [2:0] S_ERASE = 3'd5;

	logic [2:0] state_q;

	logic [sfca_pkg::SDB_W-1:0] sdb_q;
	logic [sfca_pkg::EBS_W-1:0] ebs_q;
	logic [sfca_pkg::TS_W-1:0]  ts_q;

	logic [sfca_pkg::SECTOR_W-1:0] cur_sector_q;
	logic [sfca_pkg::OFFSET_W-1:0] offset_q;

	logic [1:0]                   op_q;
	logic [sfca_pkg::BYTE_W-1:0]  wbyte_q;
	logic [sfca_pkg::RUN_W-1:0]   run_q;
	logic [SEC_W-1:0]             sec_base_q;
	logic [LIM_W-1:0]             lim_q;
	logic [SPAN_W-1:0]            span_q;
	logic [POS_W-1:0]             pos_q;
	logic [END_W-1:0]             end_q;
	logic [ADDR_W-1:0]            addr_q;
	logic [SPAN_W-1:0]            cnt_q;

	logic                         rd_s1;
	logic                         last_s1;

	logic [STRIDE_W-1:0]          stride;
	logic                         accept;
	logic [POS_W:0]               run_end;
	logic                         read_oor;
	logic                         write_ok;
	logic                         erase_ok;
	logic [SEC_W:0]               erase_end;

	logic                         mem_we;
	logic [ADDR_W-1:0]            mem_addr;
	logic [sfca_pkg::BYTE_W-1:0]  mem_wdata;
	logic [sfca_pkg::BYTE_W-1:0]  mem_rdata;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign stride = STRIDE_W'(sdb_q) + STRIDE_W'(SPARE_BYTES);

	// bounds checks on the registered addresses
	assign run_end   = (POS_W + 1)'(pos_q) + (POS_W + 1)'(run_q);
	assign read_oor  = run_end > (POS_W + 1)'(end_q);
	assign write_ok  = pos_q < POS_W'(end_q);
	assign erase_end = (SEC_W + 1)'(sec_base_q) + (SEC_W + 1)'(span_q);
	assign erase_ok  = (erase_end <= (SEC_W + 1)'(end_q)) && (span_q != '0);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sdb_q <= sfca_pkg::SDB_RESET;
			ebs_q <= sfca_pkg::EBS_RESET;
			ts_q  <= sfca_pkg::TS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sfca_pkg::CFG_SECTOR_DATA_BYTES:   sdb_q <= cfg_data[sfca_pkg::SDB_W-1:0];
				sfca_pkg::CFG_ERASE_BLOCK_SECTORS: ebs_q <= cfg_data[sfca_pkg::EBS_W-1:0];
				sfca_pkg::CFG_TOTAL_SECTORS:       ts_q  <= cfg_data[sfca_pkg::TS_W-1:0];
				default: ;
			endcase
		end
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cur_sector_q <= '0;
			offset_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (req.req_type)
							sfca_pkg::REQ_SET_SECTOR: begin
								cur_sector_q <= req.new_sector;
								offset_q     <= '0;
							end
							sfca_pkg::REQ_READ: begin
								if (req.read_length != '0) begin
									state_q <= S_MUL;
								end
							end
							default: state_q <= S_MUL;
						endcase
					end
				end
				S_MUL: state_q <= S_ADD;
				S_ADD: state_q <= S_CHK;
				S_CHK: begin
					state_q <= S_IDLE;
					unique case (op_q)
						sfca_pkg::REQ_READ: begin
							offset_q <= offset_q + sfca_pkg::OFFSET_W'(run_q);
							if (!read_oor) begin
								state_q <= S_READ;
							end
						end
						sfca_pkg::REQ_WRITE: begin
							offset_q <= offset_q + sfca_pkg::OFFSET_W'(1);
						end
						sfca_pkg::REQ_ERASE: begin
							if (erase_ok) begin
								state_q <= S_ERASE;
							end
						end
						default: ;
					endcase
				end
				S_READ, S_ERASE: begin
					if (cnt_q == SPAN_W'(1)) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request latch and address arithmetic
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.req_type;
			wbyte_q <= req.write_data;
			if (req.read_length > sfca_pkg::RUN_W'(MAX_READ_RUN)) begin
				run_q <= sfca_pkg::RUN_W'(MAX_READ_RUN);
			end else begin
				run_q <= req.read_length;
			end
		end
		if (state_q == S_MUL) begin
			sec_base_q <= SEC_W'(cur_sector_q) * SEC_W'(stride);
			lim_q      <= LIM_W'(ts_q) * LIM_W'(stride);
			span_q     <= SPAN_W'(ebs_q) * SPAN_W'(stride);
		end
		if (state_q == S_ADD) begin
			pos_q <= POS_W'(sec_base_q) + POS_W'(offset_q);
			if (lim_q < LIM_W'(CARD_BYTES)) begin
				end_q <= END_W'(lim_q);
			end else begin
				end_q <= END_W'(CARD_BYTES);
			end
		end
		// walk pointer for read runs and erase fills
		if (state_q == S_CHK) begin
			if (op_q == sfca_pkg::REQ_ERASE) begin
				addr_q <= sec_base_q[ADDR_W-1:0];
				cnt_q  <= span_q;
			end else begin
				addr_q <= pos_q[ADDR_W-1:0];
				cnt_q  <= SPAN_W'(run_q);
			end
		end else if (state_q == S_READ || state_q == S_ERASE) begin
			addr_q <= addr_q + ADDR_W'(1);
			cnt_q  <= cnt_q - SPAN_W'(1);
		end
	end

	// ram port steering
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = addr_q;
		mem_wdata = sfca_pkg::ERASED_BYTE;
		if (state_q == S_CHK) begin
			mem_addr  = pos_q[ADDR_W-1:0];
			mem_wdata = wbyte_q;
			mem_we    = (op_q == sfca_pkg::REQ_WRITE) && write_ok;
		end else if (state_q == S_ERASE) begin
			mem_we = 1'b1;
		end
	end

	sfca_ram #(
		.WIDTH (sfca_pkg::BYTE_W),
		.DEPTH (CARD_BYTES)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_addr),
		.wdata (mem_wdata),
		.raddr (mem_addr),
		.rdata (mem_rdata)
	);

	// read pipeline alongside the ram latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= (state_q == S_READ);
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= (cnt_q == SPAN_W'(1));
	end

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= rd_s1 || ((state_q == S_CHK) && (op_q == sfca_pkg::REQ_READ) && read_oor);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_s1) begin
			result.read_data   <= mem_rdata;
			result.status      <= sfca_pkg::STATUS_OK;
			result.last_of_run <= last_s1;
		end else begin
			result.read_data   <= '0;
			result.status      <= sfca_pkg::STATUS_OOR;
			result.last_of_run <= 1'b1;
		end
	end

endmodule

`default_nettype wire

/* design/sfca_checker.sv */
// sfca_checker: port level assertions for sector_flash_card_access, bound to the top
// depends on sfca_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfca_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       start,
	input wire logic                       busy,
	input wire sfca_pkg::req_t             req,
	input wire logic                       strobe,
	input wire sfca_pkg::res_t             result
);

	logic set_beat;
	logic long_beat;

	assign set_beat  = start && !busy && (req.req_type == sfca_pkg::REQ_SET_SECTOR);
	assign long_beat = start && !busy &&
		((req.req_type == sfca_pkg::REQ_READ && req.read_length != '0) ||
		 req.req_type == sfca_pkg::REQ_WRITE || req.req_type == sfca_pkg::REQ_ERASE);

	// set sector completes at once
	a_set_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		set_beat |=> !busy)
		else $error("set sector left the block busy");

	// any other real request occupies the sequencer
	a_long_busy: assert property (@(posedge clk) disable iff (!arst_n)
		long_beat |=> busy)
		else $error("request taken without going busy");

	// out of range beat is a lone zero beat
	a_oor_shape: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.status == sfca_pkg::STATUS_OOR |->
			result.last_of_run && result.read_data == '0)
		else $error("out of range beat malformed");

	// read runs stream without gaps
	a_run_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_of_run |=> strobe)
		else $error("gap inside a read run");

endmodule

bind sector_flash_card_access sfca_checker u_sfca_checker (.*);

`default_nettype wire

/* sim/tb_sector_flash_card_access.sv */
// tb_sector_flash_card_access: self-checking testbench for the sector addressed card store
// keeps its own card image and register copy, drives requests and checks every read beat
// depends on sfca_pkg and sector_flash_card_access
`timescale 1ns / 1ps

module tb_sector_flash_card_access;

	localparam longint CARD_BYTES   = 8650752;
	localparam longint SPARE_BYTES  = 16;
	localparam int     MAX_READ_RUN = 64;
	localparam int     SETTLE_LIMIT = 200000;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            start = 1'b0;
	logic                            busy;
	sfca_pkg::req_t                  req = '0;
	logic                            strobe;
	sfca_pkg::res_t                  result;
	logic                            cfg_we = 1'b0;
	logic [1:0]                      cfg_index = sfca_pkg::CFG_SECTOR_DATA_BYTES;
	logic [sfca_pkg::CFG_W-1:0]      cfg_data = '0;

	// register copy and addressing state
	logic [sfca_pkg::SDB_W-1:0]      sdb_q;
	logic [sfca_pkg::EBS_W-1:0]      ebs_q;
	logic [sfca_pkg::TS_W-1:0]       ts_q;
	logic [sfca_pkg::SECTOR_W-1:0]   sector_q;
	logic [sfca_pkg::OFFSET_W-1:0]   offset_q;

	// card image: only bytes that have been written or erased exist
	byte unsigned                    card_image[longint];
	sfca_pkg::res_t                  read_beats_due[$];
	sfca_pkg::res_t                  beat_due;
	int                              hot_sectors[$];
	int                              send_idle_pct = 34;

	int                              err_count = 0;
	int                              n_items = 0;
	int                              n_checked = 0;
	int                              n_oor = 0;

	sector_flash_card_access DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.strobe(strobe),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// geometry helpers
	function automatic longint stride_bytes();
		longint s;
		s = sdb_q;
		return s + SPARE_BYTES;
	endfunction

	function automatic longint card_limit();
		longint t;
		t = ts_q;
		t = t * stride_bytes();
		return (t < CARD_BYTES) ? t : CARD_BYTES;
	endfunction

	function automatic longint byte_pos();
		longint sec;
		longint off;
		sec = sector_q;
		off = offset_q;
		return sec * stride_bytes() + off;
	endfunction

	function automatic longint clamp_run(logic [sfca_pkg::RUN_W-1:0] len);
		return (len > MAX_READ_RUN) ? MAX_READ_RUN : len;
	endfunction

	// count of readable bytes from the current position, up to one full run
	function automatic int readable_bytes();
		longint base;
		int n;
		base = byte_pos();
		n = 0;
		while (n < MAX_READ_RUN && card_image.exists(base + n))
			n++;
		return n;
	endfunction

	// a read must either run past the card end or touch only known bytes
	function automatic bit read_is_safe(logic [sfca_pkg::RUN_W-1:0] len);
		longint run;
		run = clamp_run(len);
		if (run == 0 || byte_pos() + run > card_limit())
			return 1'b1;
		return readable_bytes() >= run;
	endfunction

	// apply one accepted request to the card image and queue its read beats
	task automatic apply_request(sfca_pkg::req_t r);
		longint base;
		longint run;
		longint span;
		longint i;
		sfca_pkg::res_t beat;
		case (r.req_type)
			sfca_pkg::REQ_SET_SECTOR: begin
				sector_q = r.new_sector;
				offset_q = '0;
			end
			sfca_pkg::REQ_READ: begin
				run = clamp_run(r.read_length);
				if (run != 0) begin
					base = byte_pos();
					offset_q = offset_q + run[sfca_pkg::OFFSET_W-1:0];
					if (base + run > card_limit()) begin
						beat.read_data = '0;
						beat.status = sfca_pkg::STATUS_OOR;
						beat.last_of_run = 1'b1;
						read_beats_due.push_back(beat);
						n_oor++;
					end else begin
						for (i = 0; i < run; i++) begin
							beat.read_data = card_image[base + i];
							beat.status = sfca_pkg::STATUS_OK;
							beat.last_of_run = (i == run - 1);
							read_beats_due.push_back(beat);
						end
					end
				end
			end
			sfca_pkg::REQ_WRITE: begin
				base = byte_pos();
				if (base < card_limit())
					card_image[base] = r.write_data;
				offset_q = offset_q + sfca_pkg::OFFSET_W'(1);
			end
			default: begin
				base = sector_q;
				base = base * stride_bytes();
				span = ebs_q;
				span = span * stride_bytes();
				if (span != 0 && base + span <= card_limit()) begin
					for (i = 0; i < span; i++)
						card_image[base + i] = sfca_pkg::ERASED_BYTE;
				end
			end
		endcase
	endtask

	// send one request, idling at random beforehand, and hold it until the block takes it
	task automatic send_req(sfca_pkg::req_t r);
		int n;
		if (r.req_type == sfca_pkg::REQ_READ && !read_is_safe(r.read_length)) begin
			n = readable_bytes();
			if (n > 0)
				r.read_length = sfca_pkg::RUN_W'(n);
			else
				r.req_type = sfca_pkg::REQ_WRITE;
		end
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		apply_request(r);
		n_items++;
	endtask

	function automatic sfca_pkg::req_t noise_req(logic [1:0] kind);
		sfca_pkg::req_t r;
		r.req_type = kind;
		r.new_sector = sfca_pkg::SECTOR_W'($urandom);
		r.write_data = sfca_pkg::BYTE_W'($urandom);
		r.read_length = sfca_pkg::RUN_W'($urandom);
		return r;
	endfunction

	task automatic do_set(logic [sfca_pkg::SECTOR_W-1:0] s);
		sfca_pkg::req_t r;
		r = noise_req(sfca_pkg::REQ_SET_SECTOR);
		r.new_sector = s;
		send_req(r);
	endtask

	task automatic do_write(logic [sfca_pkg::BYTE_W-1:0] b);
		sfca_pkg::req_t r;
		r = noise_req(sfca_pkg::REQ_WRITE);
		r.write_data = b;
		send_req(r);
	endtask

	task automatic do_read(logic [sfca_pkg::RUN_W-1:0] len);
		sfca_pkg::req_t r;
		r = noise_req(sfca_pkg::REQ_READ);
		r.read_length = len;
		send_req(r);
	endtask

	task automatic do_erase();
		send_req(noise_req(sfca_pkg::REQ_ERASE));
	endtask

	// drop start, wait for outstanding beats and for the block to go idle
	task automatic settle();
		int waited;
		start <= 1'b0;
		waited = 0;
		while (read_beats_due.size() != 0 && waited < SETTLE_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		while (busy && waited < SETTLE_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
		if (read_beats_due.size() != 0) begin
			$error("%0d read beats never arrived", read_beats_due.size());
			err_count += read_beats_due.size();
			read_beats_due.delete();
		end
	endtask

	// write all three registers on consecutive edges while idle
	task automatic load_config(logic [sfca_pkg::SDB_W-1:0] sdb,
			logic [sfca_pkg::EBS_W-1:0] ebs, logic [sfca_pkg::TS_W-1:0] ts);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= sfca_pkg::CFG_SECTOR_DATA_BYTES;
		cfg_data <= sfca_pkg::CFG_W'(sdb);
		@(posedge clk);
		cfg_index <= sfca_pkg::CFG_ERASE_BLOCK_SECTORS;
		cfg_data <= sfca_pkg::CFG_W'(ebs);
		@(posedge clk);
		cfg_index <= sfca_pkg::CFG_TOTAL_SECTORS;
		cfg_data <= sfca_pkg::CFG_W'(ts);
		@(posedge clk);
		cfg_we <= 1'b0;
		sdb_q = sdb;
		ebs_q = ebs;
		ts_q = ts;
	endtask

	function automatic logic [sfca_pkg::SECTOR_W-1:0] pick_sector();
		if ($urandom_range(99) < 80)
			return sfca_pkg::SECTOR_W'(hot_sectors[$urandom_range(hot_sectors.size() - 1)]);
		return sfca_pkg::SECTOR_W'($urandom);
	endfunction

	function automatic logic [sfca_pkg::RUN_W-1:0] rand_len(int longest);
		int pick;
		pick = $urandom_range(99);
		if (pick < 8)
			return '0;
		if (pick < 18)
			return sfca_pkg::RUN_W'($urandom_range(127, 65));
		return sfca_pkg::RUN_W'($urandom_range(longest, 1));
	endfunction

	// mostly write-then-read and erase-then-read sequences, the rest probes and noise
	task automatic random_traffic(int count);
		int stop_at;
		int kind;
		int k;
		int i;
		logic [sfca_pkg::SECTOR_W-1:0] s;
		stop_at = n_items + count;
		while (n_items < stop_at) begin
			s = pick_sector();
			kind = $urandom_range(99);
			if (kind < 40) begin
				do_set(s);
				k = $urandom_range(16, 1);
				for (i = 0; i < k; i++)
					do_write(sfca_pkg::BYTE_W'($urandom));
				do_set(s);
				repeat ($urandom_range(3, 1)) do_read(rand_len(k));
			end else if (kind < 60) begin
				do_set(s);
				do_erase();
				do_set(s);
				repeat ($urandom_range(4, 1)) do_read(rand_len(MAX_READ_RUN));
			end else if (kind < 75) begin
				do_set(sfca_pkg::SECTOR_W'($urandom));
				do_read(rand_len(MAX_READ_RUN));
				do_write(sfca_pkg::BYTE_W'($urandom));
			end else begin
				case ($urandom_range(3))
					0: do_set(s);
					1: do_read(rand_len(MAX_READ_RUN));
					2: do_write(sfca_pkg::BYTE_W'($urandom));
					default: do_erase();
				endcase
			end
		end
	endtask

	// reset geometry: writes, erase, saturated and zero reads, far end of the card
	task automatic test_default_geometry();
		send_idle_pct = 34;
		do_set(16'd0);
		do_write(8'h00);
		do_write(8'hff);
		do_write(8'ha5);
		do_set(16'd0);
		do_read(7'd3);
		do_read(7'd0);
		do_erase();
		do_read(7'd127);
		do_set(16'd16383);
		do_write(8'h5a);
		do_write(8'h3c);
		do_set(16'd16383);
		do_read(7'd2);
		// block runs past the card end, so nothing may change
		do_erase();
		do_set(16'd16383);
		do_read(7'd2);
		do_set(16'hffff);
		do_read(7'd64);
	endtask

	// zero erase block, then a card with no sectors at all
	task automatic test_degenerate_registers();
		load_config(11'd0, 7'd0, 15'd8);
		do_set(16'd3);
		do_write(8'h81);
		do_set(16'd3);
		do_erase();
		do_read(7'd1);
		load_config(11'd0, 7'd127, 15'd0);
		do_set(16'd0);
		do_read(7'd1);
		do_write(8'h7e);
		do_erase();
		do_read(7'd64);
	endtask

	// smallest sectors, exact fit of erase and reads at the card end
	task automatic test_minimal_sectors();
		send_idle_pct = 34;
		hot_sectors = '{0, 1, 4, 60, 62, 63, 64, 100};
		load_config(11'd0, 7'd4, 15'd64);
		random_traffic(75);
	endtask

	// largest sectors, card end set by the store size
	task automatic test_largest_sectors();
		send_idle_pct = 75;
		hot_sectors = '{0, 1, 4192, 4193, 4194};
		load_config(11'd2047, 7'd1, 15'd32767);
		random_traffic(75);
	endtask

	// widest erase blocks, back to back requests
	task automatic test_widest_erase_blocks();
		send_idle_pct = 0;
		hot_sectors = '{0, 7, 32640, 32700, 32766, 32767};
		load_config(11'd100, 7'd127, 15'd32767);
		random_traffic(75);
	endtask

	// compare each read beat with the oldest one outstanding
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (read_beats_due.size() == 0) begin
				$error("read beat with nothing outstanding: %h", result);
				err_count++;
			end else begin
				beat_due = read_beats_due.pop_front();
				n_checked++;
				if (result.read_data !== beat_due.read_data) begin
					$error("read_data: expected %h, got %h", beat_due.read_data,
						result.read_data);
					err_count++;
				end
				if (result.status !== beat_due.status) begin
					$error("status: expected %b, got %b", beat_due.status, result.status);
					err_count++;
				end
				if (result.last_of_run !== beat_due.last_of_run) begin
					$error("last_of_run: expected %b, got %b", beat_due.last_of_run,
						result.last_of_run);
					err_count++;
				end
			end
		end
	end

	// run limit
	initial begin
		#100_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		sdb_q = sfca_pkg::SDB_RESET;
		ebs_q = sfca_pkg::EBS_RESET;
		ts_q = sfca_pkg::TS_RESET;
		sector_q = '0;
		offset_q = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_geometry();
		test_degenerate_registers();
		test_minimal_sectors();
		test_largest_sectors();
		test_widest_erase_blocks();
		settle();
		$display("%0d requests over six register settings, %0d read beats checked",
			n_items, n_checked);
		$display("%0d reads ran past the card end", n_oor);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
